>>> sv/bubble_sort_ascending_top_assert.svh
// Assertion helpers for the sorter, clocked on aclk, held off while aresetn is low.
`ifndef BUBBLE_SORT_ASCENDING_TOP_ASSERT_SVH
`define BUBBLE_SORT_ASCENDING_TOP_ASSERT_SVH

// antecedent holds in a cycle -> consequent holds in the same cycle
`define BSA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds in a cycle -> consequent holds in the next cycle
`define BSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_pkg
// Sizes and types shared by the ascending bubble sorter.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int MAX_COUNT = 32;
    localparam int ADDR_W    = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
    localparam int CNT_W     = $clog2(MAX_COUNT + 1);
    localparam int DATA_W    = 32;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         cnt_t;

endpackage

`default_nettype wire

>>> sv/bubble_sort_ascending_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bubble_sort_ascending_top
// Collects signed words into a store, sorts them ascending, streams them out.
// ----------------------------------------------------------------------------
// Words stream in one per cycle until the word flagged with s_tlast; up to
// MAX_COUNT (32) words are kept and any beyond that are dropped, which sets
// m_tuser on every output word of that set. After the closing word s_tready
// drops while the set is sorted by passes of one signed comparator over a
// single-port-write store: a pass over the n words does one read and one
// write-back per step, carrying the larger word forward, and passes repeat
// until one makes no swap, so at most n passes. The sorted words then leave
// one at a time, each read from the store (ST_O_RD) before it is shown
// (ST_O_SHOW), the last flagged with m_tlast, after which loading resumes.
// A set of one word skips the sort.
module bubble_sort_ascending_top (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [bsa_pkg::DATA_W-1:0] s_tdata,  // [31:0] value
    input  wire logic                      s_tlast,   // last
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [bsa_pkg::DATA_W-1:0]     m_tdata,   // [31:0] sorted_value
    output logic                           m_tlast,   // last_res
    output logic                           m_tuser    // [0] overflow
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_P_INIT,
        ST_P_FIRST,
        ST_P_STEP,
        ST_P_END,
        ST_O_RD,
        ST_O_SHOW
    } state_t;

    state_t          state_reg;
    bsa_pkg::cnt_t   count_reg;
    bsa_pkg::addr_t  idx_reg;
    bsa_pkg::word_t  carry_reg;
    logic            swapped_reg;
    logic            ovf_reg;

    bsa_pkg::word_t  mem [bsa_pkg::MAX_COUNT];
    bsa_pkg::word_t  rd_data_reg;
    logic            rd_en;
    bsa_pkg::addr_t  rd_addr;
    logic            wr_en;
    bsa_pkg::addr_t  wr_addr;
    bsa_pkg::word_t  wr_data;

    logic            s_fire;
    logic            m_fire;
    logic            full;
    logic            swap;
    logic            at_end;
    bsa_pkg::cnt_t   count_next;
    bsa_pkg::addr_t  top_addr;

    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign full     = (count_reg == bsa_pkg::cnt_t'(bsa_pkg::MAX_COUNT));
    assign count_next = full ? count_reg : count_reg + bsa_pkg::cnt_t'(1);
    assign top_addr = bsa_pkg::addr_t'(count_reg - bsa_pkg::cnt_t'(1));
    assign at_end   = (idx_reg == top_addr);
    // strictly greater only, equal words stay put
    assign swap     = (carry_reg > rd_data_reg);

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_O_SHOW);
    assign m_tdata  = rd_data_reg;
    assign m_tlast  = (idx_reg == top_addr);
    assign m_tuser  = ovf_reg;

    // store port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = carry_reg;
        unique case (state_reg)
            ST_LOAD: begin
                wr_en   = s_fire && !full;
                wr_addr = bsa_pkg::addr_t'(count_reg);
                wr_data = bsa_pkg::word_t'(s_tdata);
            end
            ST_P_INIT: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            ST_P_FIRST: begin
                rd_en   = 1'b1;
                rd_addr = bsa_pkg::addr_t'(1);
            end
            ST_P_STEP: begin
                rd_en   = !at_end;
                rd_addr = idx_reg + bsa_pkg::addr_t'(1);
                wr_en   = 1'b1;
                wr_addr = idx_reg - bsa_pkg::addr_t'(1);
                wr_data = swap ? rd_data_reg : carry_reg;
            end
            ST_P_END: begin
                wr_en   = 1'b1;
                wr_addr = top_addr;
                wr_data = carry_reg;
            end
            ST_O_RD: begin
                rd_en   = 1'b1;
                rd_addr = idx_reg;
            end
            ST_O_SHOW: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            idx_reg     <= '0;
            swapped_reg <= 1'b0;
            ovf_reg     <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_fire) begin
                        count_reg <= count_next;
                        if (full) begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            idx_reg <= '0;
                            if (count_next == bsa_pkg::cnt_t'(1)) begin
                                state_reg <= ST_O_RD;
                            end else begin
                                state_reg <= ST_P_INIT;
                            end
                        end
                    end
                end
                ST_P_INIT: begin
                    swapped_reg <= 1'b0;
                    state_reg   <= ST_P_FIRST;
                end
                ST_P_FIRST: begin
                    carry_reg <= rd_data_reg;
                    idx_reg   <= bsa_pkg::addr_t'(1);
                    state_reg <= ST_P_STEP;
                end
                ST_P_STEP: begin
                    if (swap) begin
                        swapped_reg <= 1'b1;
                    end else begin
                        carry_reg <= rd_data_reg;
                    end
                    if (at_end) begin
                        state_reg <= ST_P_END;
                    end else begin
                        idx_reg <= idx_reg + bsa_pkg::addr_t'(1);
                    end
                end
                ST_P_END: begin
                    idx_reg <= '0;
                    if (swapped_reg) begin
                        state_reg <= ST_P_INIT;
                    end else begin
                        state_reg <= ST_O_RD;
                    end
                end
                ST_O_RD: begin
                    state_reg <= ST_O_SHOW;
                end
                ST_O_SHOW: begin
                    if (m_fire) begin
                        if (m_tlast) begin
                            count_reg   <= '0;
                            ovf_reg     <= 1'b0;
                            swapped_reg <= 1'b0;
                            idx_reg     <= '0;
                            state_reg   <= ST_LOAD;
                        end else begin
                            idx_reg   <= idx_reg + bsa_pkg::addr_t'(1);
                            state_reg <= ST_O_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

`include "bubble_sort_ascending_top_assert.svh"

    `BSA_ASSERT_SAME(a_no_overlap, s_tready, !m_tvalid, "input and output open together")
    `BSA_ASSERT_NEXT(a_close_stops_in, s_fire && s_tlast, !s_tready, "input open after close")
    `BSA_ASSERT_NEXT(a_last_reopens, m_fire && m_tlast, s_tready && (count_reg == '0),
                     "not back to empty load after last word")
    `BSA_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= bsa_pkg::cnt_t'(bsa_pkg::MAX_COUNT),
                     "word count beyond store size")

endmodule

`default_nettype wire

>>> test/bubble_sort_ascending_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bubble_sort_ascending_top_tb
// Streams sets of signed words into the sorter, with random gaps on the input
// side and random back-pressure on the output side. A scoreboard keeps its
// own copy of each set, sorts it when the closing word is taken, and checks
// every output word, with its last and overflow flags, in order.
// ----------------------------------------------------------------------------
module bubble_sort_ascending_top_tb;

    localparam int CLK_HALF    = 6;
    localparam int STALL_LIMIT = 10000;
    localparam int TOTAL_WORDS = 345;
    localparam int DRAIN       = 40;

    typedef struct {
        bsa_pkg::word_t value;
        logic           last;
        logic           ovf;
    } sorted_word_t;

    class sort_scoreboard;
        bsa_pkg::word_t held[$];    // words of the set being collected
        bit             dropped;
        sorted_word_t   due[$];     // sorted words not yet seen at the output
        int             errors;

        function void note_word(bsa_pkg::word_t v, bit closing);
            bsa_pkg::word_t tmp;
            bit             swapped;
            sorted_word_t   w;
            if (held.size() < bsa_pkg::MAX_COUNT)
                held.push_back(v);
            else
                dropped = 1'b1;
            if (!closing)
                return;
            do begin
                swapped = 1'b0;
                for (int i = 0; i + 1 < held.size(); i++) begin
                    if (held[i] > held[i+1]) begin
                        tmp       = held[i];
                        held[i]   = held[i+1];
                        held[i+1] = tmp;
                        swapped   = 1'b1;
                    end
                end
            end while (swapped);
            foreach (held[k]) begin
                w.value = held[k];
                w.last  = (k == held.size() - 1);
                w.ovf   = dropped;
                due.push_back(w);
            end
            held.delete();
            dropped = 1'b0;
        endfunction

        function void check_result(bsa_pkg::word_t d, logic l, logic u);
            sorted_word_t w;
            if (due.size() == 0) begin
                $error("unexpected output word %0d", d);
                errors++;
                return;
            end
            w = due.pop_front();
            if (d !== w.value) begin
                $error("sorted_value: expected %0d, got %0d", w.value, d);
                errors++;
            end
            if (l !== w.last) begin
                $error("last_res: expected %0b, got %0b", w.last, l);
                errors++;
            end
            if (u !== w.ovf) begin
                $error("overflow: expected %0b, got %0b", w.ovf, u);
                errors++;
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    sort_scoreboard sb;
    bit             steady;        // no gaps and no back-pressure while set
    int             words_sent;
    int             stall_cycles;

    bubble_sort_ascending_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #CLK_HALF aclk = ~aclk;

    function automatic bsa_pkg::word_t any_value();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return bsa_pkg::word_t'($urandom);
            6, 7:             return bsa_pkg::word_t'($urandom_range(16) - 8);  // duplicates
            8:                return {1'b0, {31{1'b1}}};
            default:          return {1'b1, 31'b0};
        endcase
    endfunction

    task automatic send_word(input bsa_pkg::word_t v, input bit closing);
        while (!steady && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= closing;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(v, closing);
        words_sent++;
    endtask

    task automatic send_random_set(input int n);
        for (int i = 0; i < n; i++)
            send_word(any_value(), i == n - 1);
    endtask

    // output side: random back-pressure, check each accepted word
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast, m_tuser);
            m_tready <= steady || ($urandom_range(99) >= 16);
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("bubble_sort_ascending_top_tb failed");
        $finish;
    end

    initial begin
        int r;
        int n;
        sb         = new();
        steady     = 1'b0;
        words_sent = 0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // one-word set, no sort pass
        send_word({1'b0, {31{1'b1}}}, 1'b1);
        // extremes reversed
        send_word({1'b0, {31{1'b1}}}, 1'b0);
        send_word({1'b1, 31'b0}, 1'b1);
        // equal words never swap
        send_word(-1, 1'b0);
        send_word(-1, 1'b1);
        // already in order
        send_word(-5, 1'b0);
        send_word(0, 1'b0);
        send_word(7, 1'b1);
        // fully reversed across the sign boundary
        send_word({1'b0, {31{1'b1}}}, 1'b0);
        send_word(1, 1'b0);
        send_word(0, 1'b0);
        send_word(-1, 1'b0);
        send_word({1'b1, 31'b0}, 1'b1);
        // duplicates mixed
        send_word(3, 1'b0);
        send_word(-3, 1'b0);
        send_word(3, 1'b0);
        send_word(0, 1'b0);
        send_word(-3, 1'b0);
        send_word(3, 1'b1);

        // exactly full, then one over with the closing word dropped
        send_random_set(bsa_pkg::MAX_COUNT);
        send_random_set(bsa_pkg::MAX_COUNT + 1);

        while (words_sent < TOTAL_WORDS) begin
            steady = (words_sent >= 150 && words_sent < 230);
            r = $urandom_range(99);
            if (r < 80)
                n = $urandom_range(8, 1);
            else if (r < 92)
                n = $urandom_range(bsa_pkg::MAX_COUNT - 1, 9);
            else
                n = $urandom_range(bsa_pkg::MAX_COUNT + 8, bsa_pkg::MAX_COUNT);
            send_random_set(n);
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("bubble_sort_ascending_top_tb passed");
        else
            $display("bubble_sort_ascending_top_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
